// ----- rtl/rc5_pkg.sv -----
// Shared types and constants for the RC5 block cipher.
`default_nettype none
package rc5_pkg;
    localparam int WORD_BITS     = 32;
    localparam int MAX_ROUNDS    = 32;
    localparam int MAX_KEY_BYTES = 16;
    localparam int TABLE_DEPTH   = 2 * MAX_ROUNDS + 2;
    localparam int TAB_AW        = $clog2(TABLE_DEPTH);
    localparam int KW_DEPTH      = (MAX_KEY_BYTES + 3) / 4;
    localparam int KW_AW         = (KW_DEPTH > 1) ? $clog2(KW_DEPTH) : 1;
    localparam int ROT_BITS      = $clog2(WORD_BITS);
    localparam logic [31:0] P32  = 32'hB7E15163;
    localparam logic [31:0] Q32  = 32'h9E3779B9;
    localparam logic [1:0] REG_KEY_LO = 2'd0;
    localparam logic [1:0] REG_KEY_HI = 2'd1;
    localparam logic [1:0] REG_KEY_LEN = 2'd2;
    localparam logic [1:0] REG_ROUNDS = 2'd3;
    localparam int CFG_IDX_BITS  = 8;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        logic               we;
        logic [TAB_AW-1:0]  waddr;
        t_word              wdata;
        logic [TAB_AW-1:0]  raddr;
    } t_tab_req;

    function automatic t_word rotl(input t_word x, input logic [ROT_BITS-1:0] s);
        logic [2*WORD_BITS-1:0] d;
        d = {x, x} << s;
        return d[2*WORD_BITS-1 -: WORD_BITS];
    endfunction

    function automatic t_word rotr(input t_word x, input logic [ROT_BITS-1:0] s);
        logic [2*WORD_BITS-1:0] d;
        d = {x, x} >> s;
        return d[WORD_BITS-1:0];
    endfunction
endpackage
`default_nettype wire

// ----- rtl/rc5_if.sv -----
// Valid/ready channel interfaces for blocks, results and configuration.
`default_nettype none
interface rc5_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] in_word_a;
    logic [31:0] in_word_b;
    modport source(output valid, operation, in_word_a, in_word_b, input ready);
    modport sink(input valid, operation, in_word_a, in_word_b, output ready);
endinterface

interface rc5_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_word_a;
    logic [31:0] out_word_b;
    modport source(output valid, out_word_a, out_word_b, input ready);
    modport sink(input valid, out_word_a, out_word_b, output ready);
endinterface

interface rc5_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [rc5_pkg::CFG_IDX_BITS-1:0]   index;
    logic [63:0]                        data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/rc5_table_ram.sv -----
// Round-key table memory, one write and one registered read port.
`default_nettype none
module rc5_table_ram (
    input  wire logic              i_clk,
    input  wire rc5_pkg::t_tab_req i_req,
    output rc5_pkg::t_word         o_rdata
);
    import rc5_pkg::*;
    t_word r_mem [TABLE_DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/rc5_engine.sv -----
// Key expansion and round sequencer around the round-key table.
`default_nettype none
module rc5_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [63:0] i_key_lo,
    input  wire logic [63:0] i_key_hi,
    input  wire logic [4:0]  i_key_len,
    input  wire logic [5:0]  i_rounds,
    input  wire logic        i_sched_clr,
    output logic             o_busy,
    rc5_in_if.sink           in_ch,
    rc5_out_if.source        out_ch
);
    import rc5_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_MIX_RD, S_MIX, S_RUN_RD, S_ENC0, S_ENC1, S_DEC0, S_DEC1,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_sched_ok;
    logic   r_op;
    t_word  r_a, r_b;
    t_word  r_ma, r_mb;
    t_word  r_kw [KW_DEPTH];
    logic [TAB_AW-1:0] r_i;
    logic [KW_AW-1:0]  r_j;
    logic [7:0]        r_k;
    logic [5:0]        r_r;
    logic [5:0]        r_rnd;
    logic [2:0]        r_c;
    logic [7:0]        r_n;
    logic [TAB_AW-1:0] r_t;
    logic              r_oval;
    t_word             r_oa, r_ob;

    t_tab_req tab_req;
    t_word    tab_rd;

    rc5_table_ram u_ram (.i_clk(i_clk), .i_req(tab_req), .o_rdata(tab_rd));

    logic [5:0] eff_r;
    logic [4:0] eff_b;
    logic [2:0] eff_c;
    logic [TAB_AW-1:0] eff_t;
    t_word mix_a, mix_b, kw_j, rk_a, rk_b;
    logic [127:0] key_all;
    logic in_fire, out_fire;

    assign eff_r = (i_rounds > 6'(MAX_ROUNDS)) ? 6'(MAX_ROUNDS) : i_rounds;
    assign eff_b = (i_key_len > 5'(MAX_KEY_BYTES)) ? 5'(MAX_KEY_BYTES) : i_key_len;
    assign eff_c = (eff_b == 5'd0) ? 3'd1 : 3'((eff_b + 5'd3) >> 2);
    assign eff_t = TAB_AW'({eff_r, 1'b0} + 7'd2);
    assign key_all = {i_key_hi, i_key_lo};
    assign kw_j = r_kw[r_j];
    assign mix_a = rotl(tab_rd + r_ma + r_mb, ROT_BITS'(3));
    assign mix_b = rotl(kw_j + mix_a + r_mb, ROT_BITS'(mix_a + r_mb));
    assign rk_a = rotl(r_a ^ r_b, ROT_BITS'(r_b)) + tab_rd;
    assign rk_b = rotl(r_b ^ r_a, ROT_BITS'(r_a)) + tab_rd;

    assign in_ch.ready = (r_state == S_IDLE) && !r_oval && !i_sched_clr;
    assign in_fire = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign out_ch.valid = r_oval;
    assign out_ch.out_word_a = r_oa;
    assign out_ch.out_word_b = r_ob;
    assign o_busy = (r_state != S_IDLE) || r_oval;

    always_comb begin
        tab_req = '0;
        tab_req.raddr = r_i;
        unique case (r_state)
            S_INIT: begin
                tab_req.we = 1'b1;
                tab_req.waddr = r_i;
                tab_req.wdata = r_ma;
            end
            S_MIX: begin
                tab_req.we = 1'b1;
                tab_req.waddr = r_i;
                tab_req.wdata = mix_a;
                tab_req.raddr = (r_i == r_t - 1'b1) ? '0 : r_i + 1'b1;
            end
            S_ENC0, S_ENC1: tab_req.raddr = r_i + 1'b1;
            S_DEC0, S_DEC1: tab_req.raddr = r_i - 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sched_ok <= 1'b0;
            r_oval <= 1'b0;
        end else begin
            if (out_fire) r_oval <= 1'b0;
            if (i_sched_clr) r_sched_ok <= 1'b0;
            unique case (r_state)
                S_IDLE: if (in_fire) begin
                    r_op <= in_ch.operation;
                    r_a <= in_ch.in_word_a;
                    r_b <= in_ch.in_word_b;
                    r_rnd <= eff_r;
                    if (!r_sched_ok) begin
                        r_t <= eff_t;
                        r_c <= eff_c;
                        r_n <= 8'(3 * ((eff_t > TAB_AW'(eff_c)) ? eff_t : TAB_AW'(eff_c)));
                        for (int w = 0; w < KW_DEPTH; w++) begin
                            for (int y = 0; y < 4; y++) begin
                                r_kw[w][8*y +: 8] <= (4*w + y < eff_b) ?
                                    key_all[8*(4*w+y) +: 8] : 8'h00;
                            end
                        end
                        r_i <= '0;
                        r_ma <= P32;
                        r_state <= S_INIT;
                    end else begin
                        r_i <= in_ch.operation ? TAB_AW'({eff_r, 1'b1}) : '0;
                        r_state <= S_RUN_RD;
                    end
                end
                S_INIT: begin
                    r_ma <= r_ma + Q32;
                    r_i <= r_i + 1'b1;
                    if (r_i == r_t - 1'b1) begin
                        r_i <= '0;
                        r_j <= '0;
                        r_k <= '0;
                        r_ma <= '0;
                        r_mb <= '0;
                        r_state <= S_MIX_RD;
                    end
                end
                S_MIX_RD: r_state <= S_MIX;
                S_MIX: begin
                    r_ma <= mix_a;
                    r_mb <= mix_b;
                    r_kw[r_j] <= mix_b;
                    r_i <= (r_i == r_t - 1'b1) ? '0 : r_i + 1'b1;
                    r_j <= (3'(r_j) == r_c - 3'd1) ? '0 : r_j + 1'b1;
                    r_k <= r_k + 8'd1;
                    if (r_k == r_n - 8'd1) begin
                        r_sched_ok <= 1'b1;
                        r_i <= r_op ? TAB_AW'({r_rnd, 1'b1}) : '0;
                        r_state <= S_RUN_RD;
                    end
                end
                S_RUN_RD: begin
                    r_r <= r_rnd;
                    r_state <= r_op ? S_DEC0 : S_ENC0;
                end
                S_ENC0: begin
                    if (r_i[0]) begin
                        r_b <= (r_i == 1) ? r_b + tab_rd : rk_b;
                        if (r_r == 0 || r_i == r_t - 1'b1) r_state <= S_DONE;
                    end else begin
                        r_a <= (r_i == 0) ? r_a + tab_rd : rk_a;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == TAB_AW'({r_rnd, 1'b1})) r_state <= S_DONE;
                end
                S_DEC0: begin
                    if (r_i[0]) begin
                        r_b <= (r_i == 1) ? r_b - tab_rd :
                               rotr(r_b - tab_rd, ROT_BITS'(r_a)) ^ r_a;
                    end else begin
                        r_a <= (r_i == 0) ? r_a - tab_rd :
                               rotr(r_a - tab_rd, ROT_BITS'(r_b)) ^ r_b;
                    end
                    r_i <= r_i - 1'b1;
                    if (r_i == 0) r_state <= S_DONE;
                end
                S_ENC1, S_DEC1: r_state <= S_DONE;
                S_DONE: begin
                    r_oa <= r_a;
                    r_ob <= r_b;
                    r_oval <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/rc5_cfg_regs.sv -----
// Configuration register file.
`default_nettype none
module rc5_cfg_regs (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_busy,
    rc5_cfg_if.sink          cfg_ch,
    output logic [63:0]      o_key_lo,
    output logic [63:0]      o_key_hi,
    output logic [4:0]       o_key_len,
    output logic [5:0]       o_rounds,
    output logic             o_sched_clr
);
    import rc5_pkg::*;
    logic fire;
    assign cfg_ch.ready = !i_busy;
    assign fire = cfg_ch.valid && cfg_ch.ready;
    assign o_sched_clr = fire && (cfg_ch.index[CFG_IDX_BITS-1:2] == '0);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_key_lo <= '0;
            o_key_hi <= '0;
            o_key_len <= 5'd16;
            o_rounds <= 6'd12;
        end else begin
            if (o_sched_clr) begin
                unique case (cfg_ch.index[1:0])
                    REG_KEY_LO:  o_key_lo <= cfg_ch.data;
                    REG_KEY_HI:  o_key_hi <= cfg_ch.data;
                    REG_KEY_LEN: o_key_len <= cfg_ch.data[4:0];
                    REG_ROUNDS:  o_rounds <= cfg_ch.data[5:0];
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/rc5_block_cipher_top.sv -----
// Top level of the RC5 block cipher.
// RC5-32 with a key of up to 16 bytes and up to 32 rounds (default 12). The first block
// after reset or a register write runs the key schedule: it fills the 2r+2 round-key
// words, reads the first one, then mixes the key words into the round-key memory. A
// block then runs one half-round per cycle, since the single read port gives one table
// word per cycle. One block is in flight at a time; input items and register writes are
// held off while a block runs or its result waits in the output register.
`default_nettype none
module rc5_block_cipher_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rc5_in_if.sink    in_ch,
    rc5_out_if.source out_ch,
    rc5_cfg_if.sink   cfg_ch
);
    import rc5_pkg::*;
    logic [63:0] key_lo, key_hi;
    logic [4:0]  key_len;
    logic [5:0]  rounds;
    logic        sched_clr, busy;

    rc5_cfg_regs u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_busy(busy), .cfg_ch(cfg_ch),
        .o_key_lo(key_lo), .o_key_hi(key_hi), .o_key_len(key_len),
        .o_rounds(rounds), .o_sched_clr(sched_clr)
    );

    rc5_engine u_eng (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_key_lo(key_lo), .i_key_hi(key_hi),
        .i_key_len(key_len), .i_rounds(rounds), .i_sched_clr(sched_clr),
        .o_busy(busy), .in_ch(in_ch), .out_ch(out_ch)
    );
endmodule
`default_nettype wire

// ----- rtl/rc5_checker.sv -----
// Port-level checks for the RC5 block cipher, bound to the top level.
`default_nettype none
module rc5_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [31:0] out_a
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_a))
        else $error("result dropped or changed while stalled");
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready)
        else $error("item accepted while result pending");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result appeared too early");
endmodule

bind rc5_block_cipher_top rc5_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_a(out_ch.out_word_a)
);
`default_nettype wire
